@@ rtl/sbr_pkg.sv @@
// Shared types and constants for the scanline background renderer.
// Used by sbr_vram, sbr_skid and scanline_background_renderer; depends on nothing.
`default_nettype none

package sbr_pkg;

  // Video memory geometry (fixed by the address field of the input word).
  localparam int unsigned VRAM_BYTES = 8192;
  localparam int unsigned VRAM_AW    = 13;

  // Default timing and queue sizing.
  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_LINE_PIXELS   = 160;
  localparam int unsigned DEF_VISIBLE_LINES = 144;
  localparam int unsigned DEF_DOTS_PER_LINE = 456;

  localparam int unsigned SEARCH_DOTS  = 80;
  localparam int unsigned VBLANK_LINES = 10;
  localparam int unsigned TILE_PIXELS  = 8;

  // Widths of the timing counters.
  localparam int unsigned DOT_W  = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned COL_W  = 9;

  // Background tile map base, as an offset into video memory.
  localparam logic [VRAM_AW-1:0] MAP_BASE = 13'h1800;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_TILE_ID = 2'd0,
    PH_LOW     = 2'd1,
    PH_HIGH    = 2'd2,
    PH_PUSH    = 2'd3
  } phase_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] pixel_y;
    logic [7:0] pixel_x;
    logic [1:0] pixel_color;
    logic       pixel_valid;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/scanline_background_renderer.sv @@
// Scanline background renderer: top level with dot timing, tile fetcher and pixel queue.
// Depends on sbr_pkg, sbr_vram and sbr_skid.
`default_nettype none

// Usage
// The slave stream carries one word per cycle. tuser selects the kind of word:
// 0 is one dot tick, 1 writes tdata's byte into video memory at tdata's offset.
// Every accepted word, tick or write, yields exactly one master word carrying the
// current mode and, on a transfer dot that shifts out a pixel, the 2-bit background
// color with its column and line (tuser high marks such a pixel).
// The result word is registered into the output or skid register. Throughput is
// one word per cycle with no bubbles while tready is high; each dot touches the video
// memory port at most once, and the fetcher's read data returns through the registered
// read port before any later dot can need it.
// Each line runs an 80-dot object search, pixel transfer until the line's pixels
// are out, then horizontal blank up to the line length; vertical blank lines
// follow the visible lines. Reset returns the timing to line 0 in object search
// with an empty queue. Video memory is not cleared: tile map and tile data must be
// written before the fetcher reads them.
// When the receiver stalls, an output register and a skid register hold up to two
// results; tready on the slave side drops only while the skid register is full.

module scanline_background_renderer #(
  parameter int unsigned QUEUE_DEPTH   = sbr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned LINE_PIXELS   = sbr_pkg::DEF_LINE_PIXELS,
  parameter int unsigned VISIBLE_LINES = sbr_pkg::DEF_VISIBLE_LINES,
  parameter int unsigned DOTS_PER_LINE = sbr_pkg::DEF_DOTS_PER_LINE
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // vram_addr[12:0], vram_data[20:13], zero pad
  input  wire logic [0:0]  s_axis_tuser_i,  // cmd[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o,  // pixel_color[1:0], pixel_x[9:2],
                                            // pixel_y[17:10], mode[19:18], zero pad
  output logic      [0:0]  m_axis_tuser_o   // pixel_valid[0]
);
  import sbr_pkg::*;

  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  // Input decode.
  logic               in_acc, is_write, is_tick;
  logic [VRAM_AW-1:0] in_addr;
  logic [7:0]         in_data;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_write = in_acc && s_axis_tuser_i[0];
  assign is_tick  = in_acc && !s_axis_tuser_i[0];
  assign in_addr  = s_axis_tdata_i[12:0];
  assign in_data  = s_axis_tdata_i[20:13];

  // Timing and fetcher state.
  mode_e             mode_q, mode_d;
  logic [DOT_W-1:0]  dot_q, dot_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  phase_e            phase_q, phase_d;
  logic              tog_q, tog_d;
  logic [4:0]        map_col_q, map_col_d;
  logic [2:0]        tile_row_q, tile_row_d;
  logic [QCW-1:0]    cnt_q, cnt_d;
  logic [1:0]        queue_q [QUEUE_DEPTH];
  logic [1:0]        queue_d [QUEUE_DEPTH];

  // Fetched tile id and the two plane bytes of the current tile row.
  logic [7:0] tile_id_q, lo_q, hi_q;

  // Memory read issue and return.
  logic               rd_en;
  logic [VRAM_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic               rd_pend_q;
  phase_e             rd_phase_q;

  // Per-dot work signals.
  logic           fetch_act, push, pop;
  logic [QCW-1:0] cnt_push;
  logic [1:0]     after_push [QUEUE_DEPTH];
  logic [QCW-1:0] diff;
  logic [2:0]     slot;
  logic [DOT_W-1:0]  dot_inc;
  logic [LINE_W-1:0] line_inc;

  result_t res;

  sbr_vram u_vram (
    .clk_i   (clk_i),
    .we_i    (is_write),
    .waddr_i (in_addr),
    .wdata_i (in_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Fetcher: it acts on every second transfer dot.
  assign fetch_act = is_tick && (mode_q == MODE_TRANSFER) && tog_q;
  assign push      = fetch_act && (phase_q == PH_PUSH)
                     && ({1'b0, cnt_q} + (QCW + 1)'(TILE_PIXELS) <= (QCW + 1)'(QUEUE_DEPTH));
  assign cnt_push  = push ? cnt_q + QCW'(TILE_PIXELS) : cnt_q;
  assign pop       = is_tick && (mode_q == MODE_TRANSFER) && (cnt_push != '0);
  assign dot_inc   = dot_q + 1'b1;
  assign line_inc  = line_q + 1'b1;

  // The read is issued at the dot itself, so a write in a later word cannot
  // overtake it; the data passes the memory's read register into the fetch registers.
  always_comb begin
    rd_en   = fetch_act && (phase_q != PH_PUSH);
    rd_addr = '0;
    case (phase_q)
      PH_TILE_ID: rd_addr = MAP_BASE + VRAM_AW'({line_q[7:3], map_col_q});
      PH_LOW:     rd_addr = {1'b0, tile_id_q, tile_row_q, 1'b0};
      PH_HIGH:    rd_addr = {1'b0, tile_id_q, tile_row_q, 1'b1};
      default:    rd_addr = '0;
    endcase
  end

  // Queue: append one tile row behind the queued pixels, then shift out the head.
  always_comb begin
    diff = '0;
    slot = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      diff          = QCW'(i) - cnt_q;
      slot          = diff[2:0];
      after_push[i] = queue_q[i];
      if (push && (QCW'(i) >= cnt_q) && (diff < QCW'(TILE_PIXELS))) begin
        // Leftmost pixel sits in bit 7 of each plane byte.
        after_push[i] = {hi_q[~slot], lo_q[~slot]};
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        queue_d[i] = after_push[(i + 1) % QUEUE_DEPTH];
      end else begin
        queue_d[i] = after_push[i];
      end
    end
  end

  // Next-state logic for the line/dot timing and the fetcher.
  always_comb begin
    mode_d     = mode_q;
    dot_d      = dot_q;
    line_d     = line_q;
    col_d      = col_q;
    phase_d    = phase_q;
    tog_d      = tog_q;
    map_col_d  = map_col_q;
    tile_row_d = tile_row_q;
    cnt_d      = cnt_q;
    if (is_tick) begin
      dot_d = dot_inc;
      case (mode_q)
        MODE_HBLANK: begin
          if (dot_inc == DOT_W'(DOTS_PER_LINE)) begin
            dot_d  = '0;
            line_d = line_inc;
            mode_d = (line_inc == LINE_W'(VISIBLE_LINES)) ? MODE_VBLANK : MODE_SEARCH;
          end
        end
        MODE_VBLANK: begin
          if (dot_inc == DOT_W'(DOTS_PER_LINE)) begin
            dot_d  = '0;
            line_d = line_inc;
            if (line_inc >= LINE_W'(VISIBLE_LINES + VBLANK_LINES)) begin
              line_d = '0;
              mode_d = MODE_SEARCH;
            end
          end
        end
        MODE_SEARCH: begin
          if (dot_inc == DOT_W'(SEARCH_DOTS)) begin
            col_d      = '0;
            tile_row_d = line_q[2:0];
            map_col_d  = '0;
            phase_d    = PH_TILE_ID;
            tog_d      = 1'b0;
            cnt_d      = '0;
            mode_d     = MODE_TRANSFER;
          end
        end
        default: begin
          tog_d = !tog_q;
          if (tog_q) begin
            case (phase_q)
              PH_TILE_ID: phase_d = PH_LOW;
              PH_LOW:     phase_d = PH_HIGH;
              PH_HIGH:    phase_d = PH_PUSH;
              default: begin
                if (push) begin
                  map_col_d = map_col_q + 1'b1;
                  phase_d   = PH_TILE_ID;
                end
              end
            endcase
          end
          cnt_d = pop ? cnt_push - 1'b1 : cnt_push;
          if (pop) begin
            col_d = col_q + 1'b1;
          end
          if ((pop ? col_q + 1'b1 : col_q) >= COL_W'(LINE_PIXELS)) begin
            mode_d = MODE_HBLANK;
          end
          // A transfer that overruns the line is cut off like horizontal blank.
          if (dot_inc == DOT_W'(DOTS_PER_LINE)) begin
            dot_d  = '0;
            line_d = line_inc;
            mode_d = (line_inc == LINE_W'(VISIBLE_LINES)) ? MODE_VBLANK : MODE_SEARCH;
          end
        end
      endcase
    end
  end

  // Result for the accepted word. The head pixel may have been pushed on this dot.
  always_comb begin
    res             = '0;
    res.mode        = mode_q;
    if (pop) begin
      res.pixel_valid = 1'b1;
      res.pixel_color = after_push[0];
      res.pixel_x     = col_q[7:0];
      res.pixel_y     = line_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SEARCH;
      dot_q      <= '0;
      line_q     <= '0;
      col_q      <= '0;
      phase_q    <= PH_TILE_ID;
      tog_q      <= 1'b0;
      map_col_q  <= '0;
      tile_row_q <= '0;
      cnt_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_phase_q <= PH_TILE_ID;
    end else begin
      mode_q     <= mode_d;
      dot_q      <= dot_d;
      line_q     <= line_d;
      col_q      <= col_d;
      phase_q    <= phase_d;
      tog_q      <= tog_d;
      map_col_q  <= map_col_d;
      tile_row_q <= tile_row_d;
      cnt_q      <= cnt_d;
      rd_pend_q  <= rd_en;
      rd_phase_q <= phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_q[i] <= queue_d[i];
    end
    if (rd_pend_q) begin
      case (rd_phase_q)
        PH_TILE_ID: tile_id_q <= rd_data;
        PH_LOW: begin
          lo_q <= rd_data;
          hi_q <= '0;
        end
        PH_HIGH:    hi_q <= rd_data;
        default:    tile_id_q <= tile_id_q;
      endcase
    end
  end

  result_t out_res;

  sbr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {4'b0, out_res.mode, out_res.pixel_y, out_res.pixel_x,
                           out_res.pixel_color};
  assign m_axis_tuser_o = out_res.pixel_valid;

  // The queue never holds more pixels than it has entries.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (QCW + 1)'(QUEUE_DEPTH))
    else $error("pixel queue count beyond depth");

  // Read data only returns for a fetch issued by a transfer dot in the cycle before.
  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(is_tick && mode_q == MODE_TRANSFER && tog_q))
    else $error("video memory read without a fetch dot");

  // A fetch read is never followed by another fetch read in the next cycle.
  a_read_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !rd_en)
    else $error("back-to-back fetch reads");

  // A pixel only leaves the block while in pixel transfer.
  a_pixel_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (mode_q == MODE_TRANSFER && cnt_push != '0))
    else $error("pixel output outside transfer");

endmodule

`default_nettype wire

@@ rtl/sbr_vram.sv @@
// Video memory: 8 KiB synchronous RAM, one write port and one registered read port.
// Depends on sbr_pkg for the address width and depth.
`default_nettype none

module sbr_vram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [sbr_pkg::VRAM_AW-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic                       re_i,
  input  wire logic [sbr_pkg::VRAM_AW-1:0] raddr_i,
  output logic      [7:0]                 rdata_o
);
  import sbr_pkg::*;

  logic [7:0] mem_q [VRAM_BYTES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbr_skid.sv @@
// Two-entry output buffer (output register plus skid register) for result words.
// Depends on sbr_pkg for the result type.
`default_nettype none

module sbr_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sbr_pkg::result_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sbr_pkg::result_t      out_data_o
);
  import sbr_pkg::*;

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    in_acc;

  assign in_ready_o  = !skid_v_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (in_acc) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_d = 1'b1;
        skid_d   = in_data_i;
      end else begin
        out_v_d = 1'b1;
        out_d   = in_data_i;
      end
    end else if (out_ready_i || !out_v_q) begin
      // The skid entry moves up when the head is taken or empty.
      out_v_d  = skid_v_q;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ verif/scanline_background_renderer_tb.sv @@
// Self-checking testbench for scanline_background_renderer: a stream driver and a monitor
// check every result word against a dot-by-dot predictor of the background pipeline.
// Depends on sbr_pkg and the renderer RTL only.
`timescale 1ns / 1ps

module scanline_background_renderer_tb;
  import sbr_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = DEF_QUEUE_DEPTH;
  localparam int unsigned LINE_PIXELS   = DEF_LINE_PIXELS;
  localparam int unsigned VISIBLE_LINES = DEF_VISIBLE_LINES;
  localparam int unsigned DOTS_PER_LINE = DEF_DOTS_PER_LINE;
  localparam int unsigned TILE_COUNT    = 4;       // tiles the map may name
  localparam int unsigned TILE_DATA_BYTES = TILE_COUNT * 16;
  localparam int unsigned MAP_ROWS      = 1;       // tile rows read by the first line
  localparam int unsigned TICK_TARGET   = 330;     // keeps the run on the first line
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned MAX_REPORTS   = 50;

  localparam bit CMD_TICK  = 1'b0;
  localparam bit CMD_WRITE = 1'b1;

  typedef struct {
    bit          cmd;
    logic [12:0] addr;
    logic [7:0]  data;
    bit          hold;  // wait for all outstanding results before sending
  } bus_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  bus_word_t   word_q [$];
  bus_word_t   cur_word;
  result_t     pixel_expect_q [$];

  int unsigned words_planned = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_checked = 0;
  int unsigned ticks_planned = 0;
  int unsigned writes_planned = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  // Predictor state, at its reset values.
  logic [7:0]  vram_mirror [0:VRAM_BYTES-1];
  mode_e       p_mode = MODE_SEARCH;
  int unsigned p_dots = 0;
  int unsigned p_line = 0;
  int unsigned p_col = 0;
  phase_e      p_phase = PH_TILE_ID;
  bit          p_half = 1'b0;
  logic [7:0]  p_tile = '0;
  logic [4:0]  p_mapcol = '0;
  logic [2:0]  p_row = '0;
  logic [1:0]  row_px [0:7] = '{default: 2'b00};
  logic [1:0]  bg_fifo [$];
  int unsigned frames_done = 0;

  scanline_background_renderer #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .LINE_PIXELS  (LINE_PIXELS),
    .VISIBLE_LINES(VISIBLE_LINES),
    .DOTS_PER_LINE(DOTS_PER_LINE)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),   // vram_addr[12:0], vram_data[20:13], zero pad
    .s_axis_tuser_i (s_tuser),   // cmd[0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),  // pixel_color[1:0], pixel_x[9:2], pixel_y[17:10],
                                       // mode[19:18], zero pad
    .m_axis_tuser_o (m_axis_tuser_o)   // pixel_valid[0]
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void finish_line();
    p_dots = 0;
    p_line++;
    p_mode = (p_line == VISIBLE_LINES) ? MODE_VBLANK : MODE_SEARCH;
  endfunction

  // Applies one word to the predicted renderer and returns the result it should produce.
  function automatic result_t step_renderer(input bit cmd, input logic [12:0] addr,
                                            input logic [7:0] data);
    result_t    r;
    logic [7:0] v;
    int         b;
    r = '0;
    r.mode = p_mode;
    if (cmd == CMD_WRITE) begin
      vram_mirror[addr] = data;
      return r;
    end
    p_dots++;
    case (p_mode)
      MODE_HBLANK: begin
        if (p_dots == DOTS_PER_LINE) finish_line();
      end
      MODE_VBLANK: begin
        if (p_dots == DOTS_PER_LINE) begin
          p_dots = 0;
          p_line++;
          if (p_line >= VISIBLE_LINES + VBLANK_LINES) begin
            p_line = 0;
            p_mode = MODE_SEARCH;
            frames_done++;
          end
        end
      end
      MODE_SEARCH: begin
        if (p_dots == SEARCH_DOTS) begin
          p_col = 0;
          p_row = 3'(p_line % 8);
          p_mapcol = '0;
          p_phase = PH_TILE_ID;
          p_half = 1'b0;
          bg_fifo.delete();
          p_mode = MODE_TRANSFER;
        end
      end
      default: begin
        // The fetcher only acts on every second transfer dot.
        if (!p_half) begin
          p_half = 1'b1;
        end else begin
          p_half = 1'b0;
          case (p_phase)
            PH_TILE_ID: begin
              p_tile = vram_mirror[(int'(MAP_BASE) + (p_line / 8) * 32 + p_mapcol) % VRAM_BYTES];
              p_phase = PH_LOW;
            end
            PH_LOW: begin
              v = vram_mirror[(p_tile * 16 + p_row * 2) % VRAM_BYTES];
              for (b = 0; b < 8; b++) row_px[b] = {1'b0, v[b]};
              p_phase = PH_HIGH;
            end
            PH_HIGH: begin
              v = vram_mirror[(p_tile * 16 + p_row * 2 + 1) % VRAM_BYTES];
              for (b = 0; b < 8; b++) row_px[b][1] = v[b];
              p_phase = PH_PUSH;
            end
            default: begin
              // The push waits for room for a whole tile row; leftmost pixel goes first.
              if (bg_fifo.size() + 8 <= QUEUE_DEPTH) begin
                for (b = 7; b >= 0; b--) bg_fifo.push_back(row_px[b]);
                p_mapcol = p_mapcol + 5'd1;
                p_phase = PH_TILE_ID;
              end
            end
          endcase
        end
        if (bg_fifo.size() != 0) begin
          r.pixel_valid = 1'b1;
          r.pixel_color = bg_fifo.pop_front();
          r.pixel_x = p_col[7:0];
          r.pixel_y = p_line[7:0];
          p_col++;
        end
        if (p_col >= LINE_PIXELS) p_mode = MODE_HBLANK;
        // A transfer still running at the line's last dot ends the line anyway.
        if (p_dots == DOTS_PER_LINE) finish_line();
      end
    endcase
    return r;
  endfunction

  // Idle cycles before the next word; long calm stretches alternate with rough ones.
  function automatic int unsigned idle_cycles(inout bit calm);
    if ($urandom_range(0, calm ? 199 : 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void plan_word(input bit cmd, input logic [12:0] addr,
                                    input logic [7:0] data, input bit hold);
    bus_word_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.data = data;
    w.hold = hold;
    word_q.push_back(w);
    words_planned++;
    if (cmd == CMD_WRITE) writes_planned++;
    else ticks_planned++;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Stream driver: predicts each accepted word and loads the next pending one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      src_wait <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        pixel_expect_q.push_back(step_renderer(cur_word.cmd, cur_word.addr, cur_word.data));
        words_sent++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_valid <= 1'b0;
        end else if (word_q.size() != 0 &&
                     !(word_q[0].hold && pixel_expect_q.size() != 0)) begin
          cur_word = word_q.pop_front();
          s_tuser <= cur_word.cmd;
          s_tdata <= {3'b000, cur_word.data, cur_word.addr};
          s_valid <= 1'b1;
          src_wait <= idle_cycles(src_calm);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int unsigned w;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (pixel_expect_q.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = pixel_expect_q.pop_front();
          if (m_axis_tuser_o[0] !== want.pixel_valid)
            report_mismatch($sformatf("word %0d pixel_valid got %b want %b",
                            results_checked, m_axis_tuser_o[0], want.pixel_valid));
          if (m_axis_tdata_o[1:0] !== want.pixel_color)
            report_mismatch($sformatf("word %0d pixel_color got %0d want %0d",
                            results_checked, m_axis_tdata_o[1:0], want.pixel_color));
          if (m_axis_tdata_o[9:2] !== want.pixel_x)
            report_mismatch($sformatf("word %0d pixel_x got %0d want %0d",
                            results_checked, m_axis_tdata_o[9:2], want.pixel_x));
          if (m_axis_tdata_o[17:10] !== want.pixel_y)
            report_mismatch($sformatf("word %0d pixel_y got %0d want %0d",
                            results_checked, m_axis_tdata_o[17:10], want.pixel_y));
          if (m_axis_tdata_o[19:18] !== want.mode)
            report_mismatch($sformatf("word %0d mode got %0d want %0d",
                            results_checked, m_axis_tdata_o[19:18], want.mode));
          if (want.pixel_valid) pixels_checked++;
          results_checked++;
        end
        w = idle_cycles(sink_calm);
        sink_wait <= w;
        m_ready <= (w == 0);
      end else if (!m_ready) begin
        if (sink_wait <= 1) begin
          m_ready <= 1'b1;
          sink_wait <= 0;
        end else begin
          sink_wait <= sink_wait - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pixel_expect_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned r;
    logic [7:0]  d;
    logic [12:0] a;

    // Directed opening: address and data extremes, alternating bit patterns and a
    // few ticks inside the object search, before anything is read from memory.
    plan_word(CMD_WRITE, 13'h1FFF, 8'hFF, 1'b0);
    plan_word(CMD_WRITE, 13'h0000, 8'h00, 1'b0);
    plan_word(CMD_WRITE, 13'h1555, 8'h5A, 1'b0);
    plan_word(CMD_WRITE, 13'h0AAA, 8'hA5, 1'b0);
    for (i = 0; i < 5; i++) plan_word(CMD_TICK, '0, '0, 1'b0);

    // Fill the data of the few tiles the map may name and the map row the first
    // line reads, so the fetcher never reads memory that was not written.
    // Tile 0 is blank and the last tile solid.
    for (i = 0; i < TILE_DATA_BYTES; i++) begin
      d = (i < 16) ? 8'h00 : (i >= TILE_DATA_BYTES - 16) ? 8'hFF : 8'($urandom);
      plan_word(CMD_WRITE, 13'(i), d, 1'b0);
    end
    for (i = 0; i < MAP_ROWS * 32; i++) begin
      d = (i % 32 == 0) ? 8'h00 : (i % 32 == 1) ? 8'(TILE_COUNT - 1) :
          8'($urandom_range(0, TILE_COUNT - 1));
      plan_word(CMD_WRITE, 13'(int'(MAP_BASE) + i), d, 1'b0);
    end

    // Run into the first transfer with a full drain first, then rewrite a map entry that
    // the line has not fetched yet and the row of tile 0 that the line reads.
    plan_word(CMD_TICK, '0, '0, 1'b1);
    for (i = 0; i < 80; i++) plan_word(CMD_TICK, '0, '0, 1'b0);
    plan_word(CMD_WRITE, 13'(int'(MAP_BASE) + 6), 8'h00, 1'b0);
    plan_word(CMD_WRITE, 13'h0000, 8'hC3, 1'b0);
    plan_word(CMD_WRITE, 13'h0001, 8'h3C, 1'b0);

    // Random part: mostly bursts of ticks with writes sprinkled in, through the
    // rest of the first line's transfer and into its horizontal blank.
    while (ticks_planned < TICK_TARGET) begin
      r = $urandom_range(0, 15);
      case (r)
        0: begin
          a = 13'($urandom);
          d = 8'($urandom);
          // A map entry may only name a tile whose data is written.
          if (a >= MAP_BASE && a < MAP_BASE + 13'(MAP_ROWS * 32))
            d = 8'($urandom_range(0, TILE_COUNT - 1));
          plan_word(CMD_WRITE, a, d, 1'b0);
        end
        1: plan_word(CMD_WRITE, 13'(int'(MAP_BASE) + $urandom_range(0, MAP_ROWS * 32 - 1)),
                     8'($urandom_range(0, TILE_COUNT - 1)), 1'b0);
        2: plan_word(CMD_WRITE, 13'($urandom_range(0, TILE_DATA_BYTES - 1)),
                     8'($urandom), 1'b0);
        default: begin
          n = $urandom_range(1, 48);
          plan_word(CMD_TICK, '0, '0, $urandom_range(0, 299) == 0);
          for (i = 1; i < n; i++) plan_word(CMD_TICK, '0, '0, 1'b0);
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != words_planned) @(posedge clk_i);
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d dot ticks and %0d memory writes; %0d full frames, ended on line %0d.",
             ticks_planned, writes_planned, frames_done, p_line);
    $display("Checked %0d result words including %0d pixels, %0d mismatches.",
             results_checked, pixels_checked, mismatches);
    if (mismatches == 0 && pixel_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sbr_pkg.sv
rtl/sbr_vram.sv
rtl/sbr_skid.sv
rtl/scanline_background_renderer.sv
verif/scanline_background_renderer_tb.sv
